[design/assert_macros.svh]
// Assertion macros used by the checker file of the shutter controller.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define TSPC_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("tspc check failed: invariant");

// The consequent must hold in the same cycle as the antecedent.
`define TSPC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tspc check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define TSPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tspc check failed: next-cycle implication");

`endif

[design/tspc_pkg.sv]
// Package for the timed shutter position controller: field widths, op codes,
// drive modes, register indexes and reset values. No dependencies.
package tspc_pkg;

  // Field widths of the channels.
  localparam int OP_BITS       = 3;
  localparam int PCT_BITS      = 7;
  localparam int POS_OUT_BITS  = 12;
  localparam int MODE_BITS     = 2;
  localparam int TRAVEL_BITS   = 12;
  localparam int PULSE_BITS    = 8;
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 12;

  // Parameter defaults.
  localparam int POSITION_BITS_DEF = 12;
  localparam int AGE_BITS_DEF      = 8;

  // A percentage maps onto the travel by this full scale.
  localparam int PERCENT_FULL = 100;

  // Command codes.
  localparam logic [OP_BITS-1:0] OP_TICK  = 3'd0;
  localparam logic [OP_BITS-1:0] OP_OPEN  = 3'd1;
  localparam logic [OP_BITS-1:0] OP_CLOSE = 3'd2;
  localparam logic [OP_BITS-1:0] OP_STOP  = 3'd3;
  localparam logic [OP_BITS-1:0] OP_SEEK  = 3'd4;
  localparam logic [OP_BITS-1:0] OP_RESET = 3'd5;

  // Drive modes.
  localparam logic [MODE_BITS-1:0] MODE_PULSE     = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_PERMANENT = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_ONOFF_DIR = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_HOLD      = 2'd3;

  // Register indexes.
  localparam logic [CFG_ADDR_BITS-1:0] CFG_DRIVE_MODE   = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_TRAVEL_TICKS = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_PULSE_TICKS  = 2'd2;

  // Register reset values.
  localparam logic [MODE_BITS-1:0]   DRIVE_MODE_RESET   = MODE_PULSE;
  localparam logic [TRAVEL_BITS-1:0] TRAVEL_TICKS_RESET = 12'd600;
  localparam logic [PULSE_BITS-1:0]  PULSE_TICKS_RESET  = 8'd5;

endpackage

[design/tspc_in_if.sv]
// Command channel of the shutter controller: valid/ready plus op and percent.
// Depends on tspc_pkg.
interface tspc_in_if;
  import tspc_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_BITS-1:0]  op;
  logic [PCT_BITS-1:0] percent;

  modport source (output valid, output op, output percent, input ready);
  modport sink (input valid, input op, input percent, output ready);
endinterface

[design/tspc_out_if.sv]
// Result channel of the shutter controller: valid/ready plus the drive lines,
// motion flags, position, target and accepted flag. Depends on tspc_pkg.
interface tspc_out_if;
  import tspc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    drive_one;
  logic                    drive_two;
  logic                    moving_up;
  logic                    moving_down;
  logic [POS_OUT_BITS-1:0] position;
  logic [POS_OUT_BITS-1:0] target;
  logic                    accepted;

  modport source (output valid, output drive_one, output drive_two, output moving_up,
                  output moving_down, output position, output target, output accepted,
                  input ready);
  modport sink (input valid, input drive_one, input drive_two, input moving_up,
                input moving_down, input position, input target, input accepted,
                output ready);
endinterface

[design/tspc_cfg_if.sv]
// Register write channel of the shutter controller: valid/ready plus register
// index and write data. Depends on tspc_pkg.
interface tspc_cfg_if;
  import tspc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CFG_ADDR_BITS-1:0] addr;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

[design/timed_shutter_position_controller.sv]
// Top level of the timed shutter position controller.
// Depends on tspc_pkg and the interfaces tspc_in_if, tspc_out_if, tspc_cfg_if.
//
//   Port   Direction  Carries
//   cmd    sink       op, percent; one command or tick per transfer
//   res    source     drive lines, motion flags, position, target, accepted
//   cfg    sink       addr, data; one register write per transfer
//
// A command is held in the input register and then loads the result
// register, so one command is taken every cycle while res does not stall.
// Division by 100 is a reciprocal multiply in the update stage. Reset (rst,
// synchronous) empties both stages, holds cmd and cfg ready low and loads
// the register reset values. When res stalls, one more command waits in the
// input register before cmd drops ready.
module timed_shutter_position_controller #(
  parameter int POSITION_BITS = tspc_pkg::POSITION_BITS_DEF,
  parameter int AGE_BITS      = tspc_pkg::AGE_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  tspc_in_if.sink    cmd,
  tspc_out_if.source res,
  tspc_cfg_if.sink   cfg
);
  import tspc_pkg::*;

  // The percent product is percent times the effective travel.
  localparam int PROD_BITS  = POSITION_BITS + PCT_BITS;
  // Dividing by 100 is a multiply by a rounded-up reciprocal. The rounding
  // error times any product stays below one unit of the shift, so the
  // truncated quotient is exact for every product.
  localparam int RSHIFT     = PROD_BITS + 7;
  localparam int RECIP_BITS = RSHIFT - 6;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << RSHIFT) + PERCENT_FULL - 1) / PERCENT_FULL;
  localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_FULL);
  localparam int SCALED_BITS = PROD_BITS + RECIP_BITS;
  // Pulse age and pulse length are compared at the wider of the two widths.
  localparam int CMP_BITS = (AGE_BITS > PULSE_BITS) ? AGE_BITS : PULSE_BITS;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [AGE_BITS-1:0]      AGE_MAX = '1;

  // The controller state that every command reads and rewrites.
  typedef struct packed {
    logic [POSITION_BITS-1:0] position_count;
    logic [POSITION_BITS-1:0] target_count;
    logic [AGE_BITS-1:0]      pulse_age;
    logic                     up_cmd;
    logic                     down_cmd;
    logic                     up_pulse;
    logic                     down_pulse;
    logic                     line_one;
    logic                     line_two;
  } ctl_t;

  // Stopping freezes the target at the current position and raises a stop
  // pulse for each direction that was running.
  function automatic ctl_t halt_motion(ctl_t s);
    ctl_t r;
    r = s;
    if (s.up_cmd || s.down_cmd) begin
      r.target_count = s.position_count;
      if (s.up_cmd) begin
        r.up_cmd   = 1'b0;
        r.up_pulse = 1'b1;
      end
      if (s.down_cmd) begin
        r.down_cmd   = 1'b0;
        r.down_pulse = 1'b1;
      end
    end
    return r;
  endfunction

  // Set a new target and start moving toward it; a fresh start in a
  // direction raises that direction's pulse.
  function automatic ctl_t seek(ctl_t s, logic [POSITION_BITS-1:0] tv);
    ctl_t r;
    r = s;
    r.target_count = tv;
    if (s.position_count > tv) begin
      if (!s.down_cmd) r.down_pulse = 1'b1;
      r.up_cmd   = 1'b0;
      r.down_cmd = 1'b1;
    end else if (s.position_count < tv) begin
      if (!s.up_cmd) r.up_pulse = 1'b1;
      r.up_cmd   = 1'b1;
      r.down_cmd = 1'b0;
    end else begin
      r.up_cmd   = 1'b0;
      r.down_cmd = 1'b0;
    end
    return r;
  endfunction

  // One tick of motion: step the counter, age the pulse, stop at the target.
  function automatic ctl_t advance(ctl_t s);
    ctl_t r;
    r = s;
    if (r.down_cmd && r.position_count != '0) r.position_count = r.position_count - 1'b1;
    if (r.up_cmd && r.position_count != POS_MAX) r.position_count = r.position_count + 1'b1;
    if ((r.up_pulse || r.down_pulse) && r.pulse_age != AGE_MAX) begin
      r.pulse_age = r.pulse_age + 1'b1;
    end
    if (r.position_count >= r.target_count && r.up_cmd) r = halt_motion(r);
    if (r.position_count <= r.target_count && r.down_cmd) r = halt_motion(r);
    return r;
  endfunction

  // Form the two drive lines in the selected mode.
  function automatic ctl_t form_lines(ctl_t s, logic [MODE_BITS-1:0] mode,
                                      logic [PULSE_BITS-1:0] pt);
    ctl_t r;
    logic young;
    r = s;
    young = CMP_BITS'(s.pulse_age) < CMP_BITS'(pt);
    case (mode)
      MODE_PULSE: begin
        if (r.up_pulse && young) begin
          r.line_one = 1'b1;
        end else begin
          r.up_pulse = 1'b0;
          r.line_one = 1'b0;
        end
        if (r.down_pulse && young) begin
          r.line_two = 1'b1;
        end else begin
          r.down_pulse = 1'b0;
          r.line_two   = 1'b0;
        end
        if (!r.up_pulse && !r.down_pulse) r.pulse_age = '0;
      end
      MODE_PERMANENT: begin
        r.line_one = r.up_cmd;
        if (!r.up_cmd) r.up_pulse = 1'b0;
        r.line_two = r.down_cmd;
        if (!r.down_cmd) r.down_pulse = 1'b0;
      end
      MODE_ONOFF_DIR: begin
        if (r.up_cmd || r.down_cmd) begin
          r.line_one = 1'b1;
        end else begin
          r.line_one = 1'b0;
          r.line_two = 1'b0;
        end
        if (r.up_cmd) r.line_two = 1'b0;
        else r.up_pulse = 1'b0;
        if (r.down_cmd) r.line_two = 1'b1;
        else r.down_pulse = 1'b0;
      end
      default: begin
        // Hold mode leaves lines and pulses as they are.
        r = s;
      end
    endcase
    return r;
  endfunction

  // Configuration registers.
  logic [MODE_BITS-1:0]   drive_mode;
  logic [TRAVEL_BITS-1:0] travel_ticks;
  logic [PULSE_BITS-1:0]  pulse_ticks;

  // Input register stage.
  logic                 a_valid;
  logic [OP_BITS-1:0]   a_op;
  logic [PROD_BITS-1:0] a_prod;

  // State and result stage.
  ctl_t cur;
  ctl_t nxt;
  ctl_t reset_view;
  logic out_valid;
  logic out_accepted;
  logic acc_next;

  // Handshake and datapath signals.
  logic                     a_load;
  logic                     b_can;
  logic                     b_load;
  logic [POSITION_BITS-1:0] trav;
  logic [SCALED_BITS-1:0]   scaled;
  logic [PROD_BITS-1:0]     quot;
  logic [POSITION_BITS-1:0] seek_tgt;

  // The update stage moves on whenever the result register is free or is
  // being emptied; the input register then always has room. Nothing is
  // taken on cmd or cfg while reset is applied.
  assign b_can     = !out_valid || res.ready;
  assign b_load    = a_valid && b_can;
  assign cmd.ready = !rst && (!a_valid || b_can);
  assign a_load    = cmd.valid && cmd.ready;
  assign cfg.ready = !rst;

  // Travel clipped to what the position counter can hold.
  always_comb begin
    if (32'(travel_ticks) > 32'(POS_MAX)) trav = POS_MAX;
    else trav = POSITION_BITS'(travel_ticks);
  end

  // Percent product divided by 100, truncated, then clamped to the travel.
  assign scaled = SCALED_BITS'(a_prod) * SCALED_BITS'(RECIP);
  assign quot   = PROD_BITS'(scaled >> RSHIFT);
  assign seek_tgt = (quot > PROD_BITS'(trav)) ? trav : POSITION_BITS'(quot);

  // Next state for the command in the input register.
  always_comb begin
    reset_view                = cur;
    reset_view.position_count = trav;
    nxt      = cur;
    acc_next = 1'b0;
    case (a_op)
      OP_TICK: begin
        nxt      = form_lines(advance(cur), drive_mode, pulse_ticks);
        acc_next = 1'b1;
      end
      OP_OPEN: begin
        if (cur.position_count < trav) begin
          nxt      = (cur.up_cmd || cur.down_cmd) ? halt_motion(cur) : seek(cur, trav);
          acc_next = 1'b1;
        end else begin
          nxt.up_cmd   = 1'b0;
          nxt.down_cmd = 1'b0;
        end
      end
      OP_CLOSE: begin
        if (cur.position_count != '0) begin
          nxt      = (cur.up_cmd || cur.down_cmd) ? halt_motion(cur) : seek(cur, '0);
          acc_next = 1'b1;
        end else begin
          nxt.up_cmd   = 1'b0;
          nxt.down_cmd = 1'b0;
        end
      end
      OP_STOP: begin
        nxt      = halt_motion(cur);
        acc_next = 1'b1;
      end
      OP_SEEK: begin
        nxt      = seek(cur, seek_tgt);
        acc_next = (cur.position_count != seek_tgt);
      end
      OP_RESET: begin
        // Jump to full travel, then run the close command from there.
        if (trav != '0) begin
          nxt = (reset_view.up_cmd || reset_view.down_cmd) ? halt_motion(reset_view)
                                                           : seek(reset_view, '0);
        end else begin
          nxt          = reset_view;
          nxt.up_cmd   = 1'b0;
          nxt.down_cmd = 1'b0;
        end
        acc_next = 1'b1;
      end
      default: begin
        // Unused codes leave the state alone and report nothing accepted.
        acc_next = 1'b0;
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_mode   <= DRIVE_MODE_RESET;
      travel_ticks <= TRAVEL_TICKS_RESET;
      pulse_ticks  <= PULSE_TICKS_RESET;
      a_valid      <= 1'b0;
      out_valid    <= 1'b0;
      cur          <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.addr)
          CFG_DRIVE_MODE:   drive_mode   <= cfg.data[MODE_BITS-1:0];
          CFG_TRAVEL_TICKS: travel_ticks <= cfg.data[TRAVEL_BITS-1:0];
          CFG_PULSE_TICKS:  pulse_ticks  <= cfg.data[PULSE_BITS-1:0];
          default: ;
        endcase
      end
      if (a_load) a_valid <= 1'b1;
      else if (b_load) a_valid <= 1'b0;
      if (b_load) begin
        cur       <= nxt;
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers. The product uses the travel in force at the transfer; registers are
  // to be written only while no command is in flight, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (a_load) begin
      a_op   <= cmd.op;
      a_prod <= PROD_BITS'(cmd.percent) * PROD_BITS'(trav);
    end
    if (b_load) out_accepted <= acc_next;
  end

  // The state changes only when a new result is loaded, so it is the result.
  assign res.valid       = out_valid;
  assign res.drive_one   = cur.line_one;
  assign res.drive_two   = cur.line_two;
  assign res.moving_up   = cur.up_cmd;
  assign res.moving_down = cur.down_cmd;
  assign res.position    = POS_OUT_BITS'(cur.position_count);
  assign res.target      = POS_OUT_BITS'(cur.target_count);
  assign res.accepted    = out_accepted;

endmodule

[design/tspc_chk.sv]
// Port-level checker for the shutter controller, bound to the top level.
// Depends on tspc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tspc_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              cmd_valid,
  input logic                              cmd_ready,
  input logic                              res_valid,
  input logic                              res_ready,
  input logic                              moving_up,
  input logic                              moving_down,
  input logic [tspc_pkg::POS_OUT_BITS-1:0] position,
  input logic [tspc_pkg::POS_OUT_BITS-1:0] target
);
  import tspc_pkg::*;

  // A stalled result stays offered.
  `TSPC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)
  // With the result register empty, a command is always taken.
  `TSPC_ASSERT_IMPL(a_cmd_free, !res_valid, cmd_ready || !cmd_valid)
  // Never both directions at once.
  `TSPC_ASSERT_ALWAYS(a_one_dir, !(res_valid && moving_up && moving_down))
  // A running motion has not yet reached its target.
  `TSPC_ASSERT_IMPL(a_up_below, res_valid && moving_up, position < target)
  `TSPC_ASSERT_IMPL(a_down_above, res_valid && moving_down, position > target)

endmodule

bind timed_shutter_position_controller tspc_chk u_tspc_chk (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .moving_up   (res.moving_up),
  .moving_down (res.moving_down),
  .position    (res.position),
  .target      (res.target)
);
